// ===== hw/rtl/ames_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Adjacency matrix edge store package
// Shared widths, operation codes, register indexes and the sequencer states.
// ----------------------------------------------------------------------------
package ames_pkg;

    localparam int MAX_VERTICES = 32;
    localparam int VTX_W        = 5;
    localparam int CNT_W        = 6;
    localparam int WGT_W        = 32;
    localparam int WADDR_W      = 2 * VTX_W;
    localparam int TDATA_W      = 48;
    localparam int PADDR_W      = 3;
    localparam int PDATA_W      = 32;

    localparam logic [CNT_W-1:0] VCNT_MAX   = CNT_W'(MAX_VERTICES);
    localparam logic [CNT_W-1:0] VCNT_RESET = CNT_W'(32);

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_SELECT = 2'd2,
        OP_FETCH  = 2'd3
    } t_op;

    typedef enum logic {
        REG_DIRECTED = 1'b0,
        REG_VCOUNT   = 1'b1
    } t_reg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROW_WR,
        ST_MIR_WR,
        ST_SCAN,
        ST_WGT
    } t_state;

endpackage

// ===== hw/rtl/ames_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with a registered read; old data on a
// read of the address being written.
// ----------------------------------------------------------------------------
module ames_ram #(
    parameter int DATA_W = 32,
    parameter int DEPTH  = 32,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/adjacency_matrix_edge_store_top.sv =====
`timescale 1ns / 1ps
// Sequencing: select row completes in the idle state; insert and remove pass through
// the row write state (and the mirror write state when an undirected edge also writes
// its mirror row); a fetch passes through the scan state and, when it hits, the weight
// read state, and waits there while the output is stalled. The next input beat is taken
// only once the item is done, back in the idle state.
// Reset clears the per-row valid flags at once, so every row reads as empty
// with no clearing pass; weights are undefined until written.
// ----------------------------------------------------------------------------
// Adjacency matrix edge store, top level
// Present bits live in a 32x32 row memory and weights in a 1024x32 memory;
// a small sequencer reads, modifies and writes rows and scans a row for the
// next present edge.
// ----------------------------------------------------------------------------
module adjacency_matrix_edge_store_top (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // Input stream
    input  logic                         i_s_axis_tvalid,
    output logic                         o_s_axis_tready,
    // tdata: source_vertex[4:0], dest_vertex[9:5], edge_weight[41:10], zero pad
    input  logic [ames_pkg::TDATA_W-1:0] i_s_axis_tdata,
    // tuser: op[1:0]
    input  logic [1:0]                   i_s_axis_tuser,
    // Output stream
    output logic                         o_m_axis_tvalid,
    input  logic                         i_m_axis_tready,
    // tdata: edge_source[4:0], edge_dest[9:5], edge_weight_out[41:10], zero pad
    output logic [ames_pkg::TDATA_W-1:0] o_m_axis_tdata,
    // tuser: edge_found[0]
    output logic                         o_m_axis_tuser,
    // Configuration port
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [ames_pkg::PADDR_W-1:0] paddr,
    input  logic [ames_pkg::PDATA_W-1:0] pwdata,
    output logic [ames_pkg::PDATA_W-1:0] prdata,
    output logic                         pready
);

    localparam int NV = ames_pkg::MAX_VERTICES;
    localparam int VW = ames_pkg::VTX_W;
    localparam int CW = ames_pkg::CNT_W;
    localparam int WW = ames_pkg::WGT_W;
    localparam int AW = ames_pkg::WADDR_W;

    ames_pkg::t_state r_state, n_state;

    logic          r_directed;
    logic [CW-1:0] r_vcount;

    ames_pkg::t_op r_op, n_op;
    logic [VW-1:0] r_src, n_src;
    logic [VW-1:0] r_dst, n_dst;
    logic [WW-1:0] r_wgt, n_wgt;
    logic          r_mirror, n_mirror;
    logic [VW-1:0] r_rd_row, n_rd_row;
    logic [VW-1:0] r_cur_row, n_cur_row;
    logic [CW-1:0] r_cur_col, n_cur_col;
    logic [VW-1:0] r_hit_col, n_hit_col;
    logic [NV-1:0] r_row_valid, n_row_valid;

    logic          r_ovalid, n_ovalid;
    logic          r_found, n_found;
    logic [VW-1:0] r_osrc, n_osrc;
    logic [VW-1:0] r_odst, n_odst;
    logic [WW-1:0] r_owgt, n_owgt;

    logic          w_prs_we, w_prs_re;
    logic [VW-1:0] w_prs_waddr, w_prs_raddr;
    logic [NV-1:0] w_prs_wdata, w_prs_rdata;
    logic          w_wgt_we, w_wgt_re;
    logic [AW-1:0] w_wgt_waddr, w_wgt_raddr;
    logic [WW-1:0] w_wgt_wdata, w_wgt_rdata;

    logic          w_accept, w_cfg_wr, w_out_free;
    ames_pkg::t_op w_in_op;
    logic [VW-1:0] w_in_src, w_in_dst;
    logic [WW-1:0] w_in_wgt;
    logic [CW-1:0] w_nact;
    logic          w_in_range;
    logic [NV-1:0] w_row, w_hits;
    logic          w_hit_any;
    logic [VW-1:0] w_hit_idx;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_directed <= 1'b0;
            r_vcount   <= ames_pkg::VCNT_RESET;
        end else if (w_cfg_wr) begin
            unique case (ames_pkg::t_reg'(paddr[2]))
                ames_pkg::REG_DIRECTED: r_directed <= pwdata[0];
                ames_pkg::REG_VCOUNT:   r_vcount   <= pwdata[CW-1:0];
                default:                r_directed <= r_directed;
            endcase
        end
    end

    always_comb begin
        unique case (ames_pkg::t_reg'(paddr[2]))
            ames_pkg::REG_DIRECTED: prdata = {{(ames_pkg::PDATA_W-1){1'b0}}, r_directed};
            ames_pkg::REG_VCOUNT:   prdata = {{(ames_pkg::PDATA_W-CW){1'b0}}, r_vcount};
            default:                prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Memories
    // ------------------------------------------------------------------
    ames_ram #(
        .DATA_W (NV),
        .DEPTH  (NV)
    ) u_present_ram (
        .i_clk   (i_clk),
        .i_we    (w_prs_we),
        .i_waddr (w_prs_waddr),
        .i_wdata (w_prs_wdata),
        .i_re    (w_prs_re),
        .i_raddr (w_prs_raddr),
        .o_rdata (w_prs_rdata)
    );

    ames_ram #(
        .DATA_W (WW),
        .DEPTH  (NV * NV)
    ) u_weight_ram (
        .i_clk   (i_clk),
        .i_we    (w_wgt_we),
        .i_waddr (w_wgt_waddr),
        .i_wdata (w_wgt_wdata),
        .i_re    (w_wgt_re),
        .i_raddr (w_wgt_raddr),
        .o_rdata (w_wgt_rdata)
    );

    // ------------------------------------------------------------------
    // Datapath helpers
    // ------------------------------------------------------------------
    assign o_s_axis_tready = (r_state == ames_pkg::ST_IDLE);
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_free      = !r_ovalid || i_m_axis_tready;

    assign w_in_op  = ames_pkg::t_op'(i_s_axis_tuser);
    assign w_in_src = i_s_axis_tdata[VW-1:0];
    assign w_in_dst = i_s_axis_tdata[2*VW-1:VW];
    assign w_in_wgt = i_s_axis_tdata[2*VW+WW-1:2*VW];

    assign w_nact     = (r_vcount > ames_pkg::VCNT_MAX) ? ames_pkg::VCNT_MAX : r_vcount;
    assign w_in_range = ({1'b0, w_in_src} < w_nact) && ({1'b0, w_in_dst} < w_nact);

    // A row never written since reset reads as empty.
    assign w_row = w_prs_rdata & {NV{r_row_valid[r_rd_row]}};

    always_comb begin
        w_hits = '0;
        for (int i = 0; i < NV; i++) begin
            w_hits[i] = w_row[i] && (CW'(i) >= r_cur_col) && (CW'(i) < w_nact);
        end
        w_hit_any = ({1'b0, r_cur_row} < w_nact) && (|w_hits);
        w_hit_idx = '0;
        for (int i = NV - 1; i >= 0; i--) begin
            if (w_hits[i]) begin
                w_hit_idx = VW'(i);
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_src       = r_src;
        n_dst       = r_dst;
        n_wgt       = r_wgt;
        n_mirror    = r_mirror;
        n_rd_row    = r_rd_row;
        n_cur_row   = r_cur_row;
        n_cur_col   = r_cur_col;
        n_hit_col   = r_hit_col;
        n_row_valid = r_row_valid;
        n_ovalid    = r_ovalid && !i_m_axis_tready;
        n_found     = r_found;
        n_osrc      = r_osrc;
        n_odst      = r_odst;
        n_owgt      = r_owgt;

        w_prs_we    = 1'b0;
        w_prs_waddr = r_src;
        w_prs_wdata = w_row;
        w_prs_re    = 1'b0;
        w_prs_raddr = r_dst;
        w_wgt_we    = 1'b0;
        w_wgt_waddr = {r_dst, r_src};
        w_wgt_wdata = r_wgt;
        w_wgt_re    = 1'b0;
        w_wgt_raddr = {r_cur_row, w_hit_idx};

        unique case (r_state)
            ames_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_op     = w_in_op;
                    n_src    = w_in_src;
                    n_dst    = w_in_dst;
                    n_wgt    = w_in_wgt;
                    n_mirror = !r_directed && (w_in_src != w_in_dst);
                    unique case (w_in_op)
                        ames_pkg::OP_INSERT, ames_pkg::OP_REMOVE: begin
                            if (w_in_range) begin
                                w_prs_re    = 1'b1;
                                w_prs_raddr = w_in_src;
                                n_rd_row    = w_in_src;
                                w_wgt_we    = (w_in_op == ames_pkg::OP_INSERT);
                                w_wgt_waddr = {w_in_src, w_in_dst};
                                w_wgt_wdata = w_in_wgt;
                                n_state     = ames_pkg::ST_ROW_WR;
                            end
                        end
                        ames_pkg::OP_SELECT: begin
                            n_cur_row = w_in_src;
                            n_cur_col = '0;
                        end
                        ames_pkg::OP_FETCH: begin
                            w_prs_re    = 1'b1;
                            w_prs_raddr = r_cur_row;
                            n_rd_row    = r_cur_row;
                            n_state     = ames_pkg::ST_SCAN;
                        end
                        default: n_state = ames_pkg::ST_IDLE;
                    endcase
                end
            end
            ames_pkg::ST_ROW_WR: begin
                w_prs_we    = 1'b1;
                w_prs_waddr = r_src;
                w_prs_wdata = (r_op == ames_pkg::OP_INSERT) ? (w_row | (NV'(1) << r_dst))
                                                           : (w_row & ~(NV'(1) << r_dst));
                n_row_valid[r_src] = 1'b1;
                if (r_mirror) begin
                    w_prs_re    = 1'b1;
                    w_prs_raddr = r_dst;
                    n_rd_row    = r_dst;
                    w_wgt_we    = (r_op == ames_pkg::OP_INSERT);
                    w_wgt_waddr = {r_dst, r_src};
                    n_state     = ames_pkg::ST_MIR_WR;
                end else begin
                    n_state = ames_pkg::ST_IDLE;
                end
            end
            ames_pkg::ST_MIR_WR: begin
                w_prs_we    = 1'b1;
                w_prs_waddr = r_dst;
                w_prs_wdata = (r_op == ames_pkg::OP_INSERT) ? (w_row | (NV'(1) << r_src))
                                                           : (w_row & ~(NV'(1) << r_src));
                n_row_valid[r_dst] = 1'b1;
                n_state            = ames_pkg::ST_IDLE;
            end
            ames_pkg::ST_SCAN: begin
                if (w_hit_any) begin
                    w_wgt_re  = 1'b1;
                    n_hit_col = w_hit_idx;
                    n_cur_col = CW'(w_hit_idx) + CW'(1);
                    n_state   = ames_pkg::ST_WGT;
                end else if (w_out_free) begin
                    n_ovalid = 1'b1;
                    n_found  = 1'b0;
                    n_osrc   = '0;
                    n_odst   = '0;
                    n_owgt   = '0;
                    n_state  = ames_pkg::ST_IDLE;
                end
            end
            ames_pkg::ST_WGT: begin
                if (w_out_free) begin
                    n_ovalid = 1'b1;
                    n_found  = 1'b1;
                    n_osrc   = r_cur_row;
                    n_odst   = r_hit_col;
                    n_owgt   = w_wgt_rdata;
                    n_state  = ames_pkg::ST_IDLE;
                end
            end
            default: n_state = ames_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ames_pkg::ST_IDLE;
            r_cur_row   <= '0;
            r_cur_col   <= '0;
            r_row_valid <= '0;
            r_ovalid    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cur_row   <= n_cur_row;
            r_cur_col   <= n_cur_col;
            r_row_valid <= n_row_valid;
            r_ovalid    <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op      <= n_op;
        r_src     <= n_src;
        r_dst     <= n_dst;
        r_wgt     <= n_wgt;
        r_mirror  <= n_mirror;
        r_rd_row  <= n_rd_row;
        r_hit_col <= n_hit_col;
        r_found   <= n_found;
        r_osrc    <= n_osrc;
        r_odst    <= n_odst;
        r_owgt    <= n_owgt;
    end

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tuser  = r_found;
    assign o_m_axis_tdata  = {{(ames_pkg::TDATA_W-2*VW-WW){1'b0}}, r_owgt, r_odst, r_osrc};

`ifndef ASSERT_OFF
    a_result_from_fetch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> ($past(r_state) == ames_pkg::ST_SCAN ||
                             $past(r_state) == ames_pkg::ST_WGT))
        else $error("result appeared outside a fetch");

    a_row_write_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_prs_we |-> (r_state == ames_pkg::ST_ROW_WR || r_state == ames_pkg::ST_MIR_WR))
        else $error("row memory written outside a row update");

    a_no_row_collision: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_prs_we && w_prs_re) |-> (w_prs_waddr != w_prs_raddr))
        else $error("row read and write hit the same entry");

    a_miss_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && !r_found) |-> (r_osrc == '0 && r_odst == '0 && r_owgt == '0))
        else $error("not-found result carries a nonzero payload");

    a_cursor_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cur_col <= ames_pkg::VCNT_MAX)
        else $error("cursor column beyond the matrix");
`endif

endmodule

// ===== bench/tb_adjacency_matrix_edge_store_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Adjacency matrix edge store testbench
// Streams insert, remove, select-row and fetch-next commands into the block
// under bursty input and a stalling output, and keeps its own matrix of
// present bits, weights and the row cursor. Every fetch result is compared
// field by field with the edge that the matrix says is next. The graph mode
// and the vertex count are rewritten over APB between phases and read back.
// ----------------------------------------------------------------------------
module tb_adjacency_matrix_edge_store_top;

    localparam int CLK_HALF    = 5;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_ITEMS = 50;
    localparam int SETTLE      = 8;

    typedef struct packed {
        ames_pkg::t_op                  op;
        logic [ames_pkg::VTX_W-1:0]     src;
        logic [ames_pkg::VTX_W-1:0]     dst;
        logic [ames_pkg::WGT_W-1:0]     wgt;
    } t_edge_cmd;

    typedef struct packed {
        logic                           found;
        logic [ames_pkg::VTX_W-1:0]     src;
        logic [ames_pkg::VTX_W-1:0]     dst;
        logic [ames_pkg::WGT_W-1:0]     wgt;
    } t_edge_hit;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_RANDOM,
        RX_MASK,
        RX_HOLD
    } t_rx_mode;

    logic                           i_clk           = 1'b0;
    logic                           i_rst_n         = 1'b0;
    logic                           i_s_axis_tvalid = 1'b0;
    logic                           o_s_axis_tready;
    logic [ames_pkg::TDATA_W-1:0]   i_s_axis_tdata  = '0;
    logic [1:0]                     i_s_axis_tuser  = '0;
    logic                           o_m_axis_tvalid;
    logic                           i_m_axis_tready = 1'b0;
    logic [ames_pkg::TDATA_W-1:0]   o_m_axis_tdata;
    logic                           o_m_axis_tuser;
    logic                           psel            = 1'b0;
    logic                           penable         = 1'b0;
    logic                           pwrite          = 1'b0;
    logic [ames_pkg::PADDR_W-1:0]   paddr           = '0;
    logic [ames_pkg::PDATA_W-1:0]   pwdata          = '0;
    logic [ames_pkg::PDATA_W-1:0]   prdata;
    logic                           pready;

    adjacency_matrix_edge_store_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // Shadow copy of the matrix, the cursor and the two registers.
    logic [ames_pkg::MAX_VERTICES-1:0] shadow_rows [ames_pkg::MAX_VERTICES];
    logic [ames_pkg::WGT_W-1:0]
        shadow_wgts [ames_pkg::MAX_VERTICES*ames_pkg::MAX_VERTICES];
    logic [ames_pkg::VTX_W-1:0]        shadow_cur_row  = '0;
    logic [ames_pkg::CNT_W-1:0]        shadow_cur_col  = '0;
    logic                              shadow_directed = 1'b0;
    logic [ames_pkg::CNT_W-1:0]        shadow_vcount   = ames_pkg::VCNT_RESET;

    t_edge_cmd pending_cmds [$];
    t_edge_hit fetch_results_due [$];

    int  cmds_queued    = 0;
    int  cmds_accepted  = 0;
    int  mismatch_count = 0;
    int  result_beats   = 0;
    int  cycle_count    = 0;
    logic in_taken      = 1'b0;

    int        burst_left = 0;
    int        gap_left   = 0;
    t_edge_cmd next_cmd;

    t_rx_mode  rx_mode = RX_OPEN;
    int        rx_left = 0;
    logic [31:0] rx_mask = '1;

    initial begin
        for (int r = 0; r < ames_pkg::MAX_VERTICES; r++) begin
            shadow_rows[r] = '0;
        end
    end

    function automatic int vertices_in_use();
        return (int'(shadow_vcount) > ames_pkg::MAX_VERTICES) ?
               ames_pkg::MAX_VERTICES : int'(shadow_vcount);
    endfunction

    task automatic flag_mismatch(string what, logic [63:0] exp_v, logic [63:0] got_v);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("%s differs at beat %0d: expected %h, got %h",
                     what, result_beats, exp_v, got_v);
        end
    endtask

    task automatic apply_edge_cmd(t_edge_cmd c);
        int        n;
        int        col;
        logic      hit;
        t_edge_hit res;
        n = vertices_in_use();
        case (c.op)
            ames_pkg::OP_INSERT, ames_pkg::OP_REMOVE: begin
                if (int'(c.src) < n && int'(c.dst) < n) begin
                    if (c.op == ames_pkg::OP_INSERT) begin
                        shadow_rows[c.src][c.dst] = 1'b1;
                        shadow_wgts[{c.src, c.dst}] = c.wgt;
                        if (!shadow_directed) begin
                            shadow_rows[c.dst][c.src] = 1'b1;
                            shadow_wgts[{c.dst, c.src}] = c.wgt;
                        end
                    end else begin
                        shadow_rows[c.src][c.dst] = 1'b0;
                        if (!shadow_directed) begin
                            shadow_rows[c.dst][c.src] = 1'b0;
                        end
                    end
                end
            end
            ames_pkg::OP_SELECT: begin
                shadow_cur_row = c.src;
                shadow_cur_col = '0;
            end
            default: begin
                res = '0;
                hit = 1'b0;
                if (int'(shadow_cur_row) < n) begin
                    for (col = int'(shadow_cur_col); col < n && !hit; col++) begin
                        if (shadow_rows[shadow_cur_row][col]) begin
                            hit       = 1'b1;
                            res.found = 1'b1;
                            res.src   = shadow_cur_row;
                            res.dst   = ames_pkg::VTX_W'(col);
                            res.wgt   = shadow_wgts[{shadow_cur_row,
                                                     ames_pkg::VTX_W'(col)}];
                            shadow_cur_col = ames_pkg::CNT_W'(col + 1);
                        end
                    end
                end
                fetch_results_due.push_back(res);
            end
        endcase
    endtask

    task automatic check_result_beat();
        t_edge_hit want;
        result_beats++;
        if (fetch_results_due.size() == 0) begin
            flag_mismatch("unexpected result", '0, 64'({o_m_axis_tuser, o_m_axis_tdata}));
        end else begin
            want = fetch_results_due.pop_front();
            if (o_m_axis_tuser !== want.found) begin
                flag_mismatch("edge_found", 64'(want.found), 64'(o_m_axis_tuser));
            end
            if (o_m_axis_tdata[4:0] !== want.src) begin
                flag_mismatch("edge_source", 64'(want.src), 64'(o_m_axis_tdata[4:0]));
            end
            if (o_m_axis_tdata[9:5] !== want.dst) begin
                flag_mismatch("edge_dest", 64'(want.dst), 64'(o_m_axis_tdata[9:5]));
            end
            if (o_m_axis_tdata[41:10] !== want.wgt) begin
                flag_mismatch("edge_weight_out", 64'(want.wgt),
                              64'(o_m_axis_tdata[41:10]));
            end
            if (o_m_axis_tdata[ames_pkg::TDATA_W-1:42] !== '0) begin
                flag_mismatch("tdata padding", '0,
                              64'(o_m_axis_tdata[ames_pkg::TDATA_W-1:42]));
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_taken <= 1'b0;
        end else begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                check_result_beat();
            end
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                apply_edge_cmd('{op:  ames_pkg::t_op'(i_s_axis_tuser),
                                 src: i_s_axis_tdata[4:0],
                                 dst: i_s_axis_tdata[9:5],
                                 wgt: i_s_axis_tdata[41:10]});
                cmds_accepted++;
            end
            in_taken <= i_s_axis_tvalid && o_s_axis_tready;
        end
    end

    always @(negedge i_clk) begin
        if (i_rst_n && (!i_s_axis_tvalid || in_taken)) begin
            if (i_s_axis_tvalid) begin
                burst_left--;
                if (burst_left <= 0) begin
                    gap_left = $urandom_range(0, 8);
                end
            end
            if (gap_left > 0) begin
                gap_left--;
                i_s_axis_tvalid <= 1'b0;
            end else if (pending_cmds.size() > 0) begin
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 24);
                end
                next_cmd = pending_cmds.pop_front();
                i_s_axis_tdata  <= ames_pkg::TDATA_W'({next_cmd.wgt, next_cmd.dst,
                                                       next_cmd.src});
                i_s_axis_tuser  <= next_cmd.op;
                i_s_axis_tvalid <= 1'b1;
            end else begin
                i_s_axis_tvalid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (rx_left <= 0) begin
            rx_mode = t_rx_mode'($urandom_range(0, 3));
            rx_left = $urandom_range(8, 64);
            rx_mask = $urandom();
        end
        rx_left--;
        case (rx_mode)
            RX_OPEN:   i_m_axis_tready <= 1'b1;
            RX_RANDOM: i_m_axis_tready <= ($urandom_range(0, 3) != 0);
            RX_MASK:   i_m_axis_tready <= rx_mask[rx_left % 32];
            default:   i_m_axis_tready <= (rx_left < 3);
        endcase
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("adjacency_matrix_edge_store_top: mismatch");
            $finish;
        end
    end

    task automatic queue_cmd(ames_pkg::t_op op, logic [ames_pkg::VTX_W-1:0] s,
                             logic [ames_pkg::VTX_W-1:0] d,
                             logic [ames_pkg::WGT_W-1:0] w);
        pending_cmds.push_back('{op: op, src: s, dst: d, wgt: w});
        cmds_queued++;
    endtask

    task automatic wait_drained();
        while (!(cmds_accepted == cmds_queued && fetch_results_due.size() == 0)) begin
            @(negedge i_clk);
        end
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic apb_write(ames_pkg::t_reg idx, logic [ames_pkg::PDATA_W-1:0] data);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = ames_pkg::PADDR_W'(4 * int'(idx));
        pwdata  = data;
        @(negedge i_clk);
        penable = 1'b1;
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        if (idx == ames_pkg::REG_DIRECTED) begin
            shadow_directed = data[0];
        end else begin
            shadow_vcount = data[ames_pkg::CNT_W-1:0];
        end
    endtask

    task automatic apb_read_check(ames_pkg::t_reg idx);
        logic [ames_pkg::PDATA_W-1:0] want;
        logic [ames_pkg::PDATA_W-1:0] got;
        want = (idx == ames_pkg::REG_DIRECTED) ? ames_pkg::PDATA_W'(shadow_directed)
                                               : ames_pkg::PDATA_W'(shadow_vcount);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = ames_pkg::PADDR_W'(4 * int'(idx));
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        got = prdata;
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        if (got !== want) begin
            flag_mismatch("register readback", 64'(want), 64'(got));
        end
    endtask

    task automatic set_graph_mode(logic dir, logic [ames_pkg::CNT_W-1:0] cnt);
        wait_drained();
        apb_write(ames_pkg::REG_DIRECTED,
                  ($urandom() & ~32'h1) | ames_pkg::PDATA_W'(dir));
        apb_write(ames_pkg::REG_VCOUNT,
                  ($urandom() & ~32'h3F) | ames_pkg::PDATA_W'(cnt));
        apb_read_check(ames_pkg::REG_DIRECTED);
        apb_read_check(ames_pkg::REG_VCOUNT);
    endtask

    function automatic logic [ames_pkg::VTX_W-1:0] pick_vertex(int n);
        int r;
        r = $urandom_range(0, 99);
        if (n == 0 || r < 25) begin
            return ames_pkg::VTX_W'($urandom_range(0, ames_pkg::MAX_VERTICES - 1));
        end else if (r < 75) begin
            return ames_pkg::VTX_W'($urandom_range(0, ((n < 6) ? n : 6) - 1));
        end
        return ames_pkg::VTX_W'($urandom_range(0, n - 1));
    endfunction

    function automatic logic [ames_pkg::WGT_W-1:0] pick_weight();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) begin
            return '0;
        end else if (r == 1) begin
            return '1;
        end
        return $urandom();
    endfunction

    task automatic queue_random_phase(int items);
        int n;
        int r;
        int k;
        int made;
        n    = vertices_in_use();
        made = 0;
        while (made < items) begin
            r = $urandom_range(0, 99);
            if (r < 35) begin
                k = $urandom_range(1, 4);
                repeat (k) queue_cmd(ames_pkg::OP_INSERT, pick_vertex(n), pick_vertex(n),
                                     pick_weight());
                made += k;
            end else if (r < 50) begin
                queue_cmd(ames_pkg::OP_REMOVE, pick_vertex(n), pick_vertex(n),
                          pick_weight());
                made++;
            end else if (r < 92) begin
                k = $urandom_range(1, 8);
                queue_cmd(ames_pkg::OP_SELECT, pick_vertex(n), pick_vertex(n),
                          pick_weight());
                repeat (k) queue_cmd(ames_pkg::OP_FETCH, pick_vertex(n), pick_vertex(n),
                                     pick_weight());
                made += k + 1;
            end else begin
                queue_cmd(ames_pkg::t_op'($urandom_range(0, 3)),
                          ames_pkg::VTX_W'($urandom()),
                          ames_pkg::VTX_W'($urandom()), $urandom());
                made++;
            end
        end
    endtask

    logic mode_dir [11] = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0,
                            1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
    logic [ames_pkg::CNT_W-1:0] mode_cnt [11] = '{6'd32, 6'd5, 6'd1, 6'd0, 6'd63, 6'd32,
                                                  6'd2, 6'd40, 6'd17, 6'd31, 6'd32};

    initial begin
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        apb_read_check(ames_pkg::REG_DIRECTED);
        apb_read_check(ames_pkg::REG_VCOUNT);

        // Undirected graph of 32 vertices straight out of reset.
        queue_cmd(ames_pkg::OP_INSERT, 5'd0,  5'd0,  32'h0000_0000);
        queue_cmd(ames_pkg::OP_INSERT, 5'd31, 5'd31, 32'hFFFF_FFFF);
        queue_cmd(ames_pkg::OP_INSERT, 5'd0,  5'd31, 32'hA5A5_5A5A);
        queue_cmd(ames_pkg::OP_INSERT, 5'd3,  5'd5,  32'h1234_5678);
        queue_cmd(ames_pkg::OP_INSERT, 5'd3,  5'd5,  32'hDEAD_BEEF);
        queue_cmd(ames_pkg::OP_SELECT, 5'd0,  5'd0,  32'h0);
        queue_cmd(ames_pkg::OP_FETCH,  5'd0,  5'd0,  32'h0);
        queue_cmd(ames_pkg::OP_FETCH,  5'd0,  5'd0,  32'h0);
        queue_cmd(ames_pkg::OP_FETCH,  5'd0,  5'd0,  32'h0);
        queue_cmd(ames_pkg::OP_FETCH,  5'd31, 5'd31, 32'hFFFF_FFFF);
        queue_cmd(ames_pkg::OP_SELECT, 5'd31, 5'd0,  32'h0);
        queue_cmd(ames_pkg::OP_FETCH,  5'd0,  5'd0,  32'h0);
        queue_cmd(ames_pkg::OP_FETCH,  5'd0,  5'd0,  32'h0);
        queue_cmd(ames_pkg::OP_REMOVE, 5'd31, 5'd0,  32'h0);
        queue_cmd(ames_pkg::OP_SELECT, 5'd0,  5'd0,  32'h0);
        queue_cmd(ames_pkg::OP_FETCH,  5'd0,  5'd0,  32'h0);
        queue_cmd(ames_pkg::OP_FETCH,  5'd0,  5'd0,  32'h0);
        queue_cmd(ames_pkg::OP_SELECT, 5'd5,  5'd0,  32'h0);
        queue_cmd(ames_pkg::OP_FETCH,  5'd0,  5'd0,  32'h0);
        queue_cmd(ames_pkg::OP_REMOVE, 5'd5,  5'd3,  32'hFFFF_FFFF);
        queue_cmd(ames_pkg::OP_SELECT, 5'd3,  5'd0,  32'h0);
        queue_cmd(ames_pkg::OP_FETCH,  5'd0,  5'd0,  32'h0);
        queue_cmd(ames_pkg::OP_INSERT, 5'd10, 5'd20, 32'h5555_AAAA);
        queue_cmd(ames_pkg::OP_SELECT, 5'd20, 5'd0,  32'h0);
        queue_cmd(ames_pkg::OP_FETCH,  5'd0,  5'd0,  32'h0);

        for (int p = 0; p < 11; p++) begin
            set_graph_mode(mode_dir[p], mode_cnt[p]);
            queue_random_phase(PHASE_ITEMS);
        end

        wait_drained();
        repeat (SETTLE) @(negedge i_clk);
        if (mismatch_count == 0) begin
            $display("adjacency_matrix_edge_store_top: match");
        end else begin
            $display("adjacency_matrix_edge_store_top: mismatch");
        end
        $finish;
    end

endmodule
